// ----- src/lwpw_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lwpw_pkg
// Shared types and constants of the LCD window pixel writer.
// ---------------------------------------------------------------------------
package lwpw_pkg;

    localparam int DEF_DISPLAY_WIDTH  = 240;
    localparam int DEF_DISPLAY_HEIGHT = 320;
    localparam int DEF_MAX_REPEAT     = 32;

    localparam int COORD_W   = 16;
    localparam int COLOR_W   = 8;
    localparam int REPEAT_W  = 6;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 17;
    localparam int IDX_W     = 6;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;

    localparam int XA_LSB  = 0;
    localparam int YA_LSB  = 16;
    localparam int XB_LSB  = 32;
    localparam int YB_LSB  = 48;
    localparam int RED_LSB = 64;
    localparam int GRN_LSB = 72;
    localparam int BLU_LSB = 80;
    localparam int REP_LSB = 88;

    localparam logic [BYTE_W-1:0] CMD_COLUMN_SET   = 8'h2A;
    localparam logic [BYTE_W-1:0] CMD_PAGE_SET     = 8'h2B;
    localparam logic [BYTE_W-1:0] CMD_MEMORY_WRITE = 8'h2C;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    localparam logic OP_WINDOW = 1'b0;
    localparam logic OP_PIXEL  = 1'b1;

    // window byte sequence positions
    localparam logic [IDX_W-1:0] WIN_CMD_COL  = 6'd0;
    localparam logic [IDX_W-1:0] WIN_CMIN_HI  = 6'd1;
    localparam logic [IDX_W-1:0] WIN_CMIN_LO  = 6'd2;
    localparam logic [IDX_W-1:0] WIN_CMAX_HI  = 6'd3;
    localparam logic [IDX_W-1:0] WIN_CMAX_LO  = 6'd4;
    localparam logic [IDX_W-1:0] WIN_CMD_PAGE = 6'd5;
    localparam logic [IDX_W-1:0] WIN_RMIN_HI  = 6'd6;
    localparam logic [IDX_W-1:0] WIN_RMIN_LO  = 6'd7;
    localparam logic [IDX_W-1:0] WIN_RMAX_HI  = 6'd8;
    localparam logic [IDX_W-1:0] WIN_RMAX_LO  = 6'd9;
    localparam logic [IDX_W-1:0] WIN_CMD_MEM  = 6'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_MUL,
        S_WIN,
        S_PIX
    } t_state;

    typedef struct packed {
        logic load_in;
        logic calc;
        logic mul;
        logic emit_win;
        logic emit_pix;
    } t_dp_cmd;

    typedef struct packed {
        logic in_op;
        logic in_zero;
        logic out_free;
        logic win_last;
        logic pix_last;
    } t_dp_status;

endpackage
`default_nettype wire

// ----- src/lwpw_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lwpw_ctrl
// Sequencer: input acceptance and window / pixel byte emission control.
// ---------------------------------------------------------------------------
module lwpw_ctrl
    import lwpw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        logic take;
        take       = 1'b0;
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                take       = i_in_valid;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_WIN;
            end
            S_WIN: begin
                o_cmd.emit_win = i_status.out_free;
                if (i_status.out_free && i_status.win_last) begin
                    n_state = S_IDLE;
                end
            end
            S_PIX: begin
                o_cmd.emit_pix = i_status.out_free;
                if (i_status.out_free && i_status.pix_last) begin
                    // last byte leaves: take the next item in the same cycle
                    n_state    = S_IDLE;
                    o_in_ready = 1'b1;
                    take       = i_in_valid;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (!i_rst_n) begin
            o_in_ready = 1'b0;
            take       = 1'b0;
        end
        if (take) begin
            o_cmd.load_in = 1'b1;
            if (i_status.in_op == OP_WINDOW) begin
                n_state = S_CALC;
            end else if (!i_status.in_zero) begin
                n_state = S_PIX;
            end else begin
                n_state = S_IDLE;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/lwpw_dp.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lwpw_dp
// Datapath: corner ordering and clipping, pixel count, RGB565 packing,
// byte sequencing and the output register.
// ---------------------------------------------------------------------------
module lwpw_dp
    import lwpw_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = DEF_DISPLAY_WIDTH,
    parameter int DISPLAY_HEIGHT = DEF_DISPLAY_HEIGHT,
    parameter int MAX_REPEAT     = DEF_MAX_REPEAT
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [IN_TDATA_W-1:0]  i_in_data,
    input  wire logic                   i_in_op,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_status                  o_status,
    input  wire logic                   i_out_ready,
    output logic                        o_out_valid,
    output logic [OUT_TDATA_W-1:0]      o_out_data,
    output logic [OUT_TUSER_W-1:0]      o_out_user,
    output logic                        o_out_last
);

    localparam int SPAN_CW = $clog2(DISPLAY_WIDTH + 1);
    localparam int SPAN_RW = $clog2(DISPLAY_HEIGHT + 1);
    localparam logic [COORD_W-1:0] WLIM = COORD_W'(DISPLAY_WIDTH - 1);
    localparam logic [COORD_W-1:0] HLIM = COORD_W'(DISPLAY_HEIGHT - 1);
    localparam logic [REPEAT_W-1:0] REP_LIM = REPEAT_W'(MAX_REPEAT);

    logic [COORD_W-1:0]  r_xa, r_ya, r_xb, r_yb;
    logic [COORD_W-1:0]  r_cmin, r_cmax, r_rmin, r_rmax;
    logic                r_empty;
    logic [COUNT_W-1:0]  r_count;
    logic [BYTE_W-1:0]   r_hi, r_lo;
    logic [REPEAT_W-1:0] r_rep;
    logic [IDX_W-1:0]    r_idx;

    logic                r_out_valid;
    logic                r_out_wv;
    logic                r_out_isd;
    logic [BYTE_W-1:0]   r_out_byte;
    logic [COUNT_W-1:0]  r_out_count;
    logic                r_out_last;

    logic [REPEAT_W-1:0] in_rep;
    logic [COLOR_W-1:0]  in_red, in_grn, in_blu;
    logic [COORD_W-1:0]  cmin, cmax, rmin, rmax;
    logic [SPAN_CW-1:0]  span_c;
    logic [SPAN_RW-1:0]  span_r;
    logic [31:0]         prod;
    logic                emit;
    logic                win_last;
    logic                pix_last;
    logic [REPEAT_W-1:0] rep_m1;
    logic [BYTE_W-1:0]   win_byte;
    logic                win_isd;

    assign in_rep = i_in_data[REP_LSB +: REPEAT_W];
    assign in_red = i_in_data[RED_LSB +: COLOR_W];
    assign in_grn = i_in_data[GRN_LSB +: COLOR_W];
    assign in_blu = i_in_data[BLU_LSB +: COLOR_W];

    // order and clip
    always_comb begin
        cmin = (r_xa < r_xb) ? r_xa : r_xb;
        cmax = (r_xa < r_xb) ? r_xb : r_xa;
        rmin = (r_ya < r_yb) ? r_ya : r_yb;
        rmax = (r_ya < r_yb) ? r_yb : r_ya;
        if (cmax > WLIM) cmax = WLIM;
        if (rmax > HLIM) rmax = HLIM;
    end

    assign span_c = SPAN_CW'(r_cmax - r_cmin + COORD_W'(1));
    assign span_r = SPAN_RW'(r_rmax - r_rmin + COORD_W'(1));
    assign prod   = 32'(span_c) * 32'(span_r);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_xa  <= i_in_data[XA_LSB +: COORD_W];
            r_ya  <= i_in_data[YA_LSB +: COORD_W];
            r_xb  <= i_in_data[XB_LSB +: COORD_W];
            r_yb  <= i_in_data[YB_LSB +: COORD_W];
            r_hi  <= {in_red[7:3], in_grn[7:5]};
            r_lo  <= {in_grn[4:2], in_blu[7:3]};
            r_rep <= (in_rep > REP_LIM) ? REP_LIM : in_rep;
        end
        if (i_cmd.calc) begin
            r_cmin  <= cmin;
            r_cmax  <= cmax;
            r_rmin  <= rmin;
            r_rmax  <= rmax;
            r_empty <= (cmin > cmax) || (rmin > rmax);
        end
        if (i_cmd.mul) begin
            r_count <= (prod > 32'(COUNT_MAX)) ? COUNT_MAX : prod[COUNT_W-1:0];
        end
    end

    assign emit = i_cmd.emit_win || i_cmd.emit_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load_in) begin
            r_idx <= '0;
        end else if (emit) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    assign rep_m1   = r_rep - REPEAT_W'(1);
    assign pix_last = r_idx[0] && (r_idx[IDX_W-1:1] == rep_m1[IDX_W-2:0]);
    assign win_last = r_empty || (r_idx == WIN_CMD_MEM);

    always_comb begin
        win_isd = 1'b1;
        case (r_idx)
            WIN_CMD_COL: begin
                win_byte = CMD_COLUMN_SET;
                win_isd  = 1'b0;
            end
            WIN_CMIN_HI:  win_byte = r_cmin[15:8];
            WIN_CMIN_LO:  win_byte = r_cmin[7:0];
            WIN_CMAX_HI:  win_byte = r_cmax[15:8];
            WIN_CMAX_LO:  win_byte = r_cmax[7:0];
            WIN_CMD_PAGE: begin
                win_byte = CMD_PAGE_SET;
                win_isd  = 1'b0;
            end
            WIN_RMIN_HI:  win_byte = r_rmin[15:8];
            WIN_RMIN_LO:  win_byte = r_rmin[7:0];
            WIN_RMAX_HI:  win_byte = r_rmax[15:8];
            WIN_RMAX_LO:  win_byte = r_rmax[7:0];
            default: begin
                win_byte = CMD_MEMORY_WRITE;
                win_isd  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_win) begin
            if (r_empty) begin
                r_out_wv    <= 1'b0;
                r_out_isd   <= 1'b0;
                r_out_byte  <= '0;
                r_out_count <= '0;
                r_out_last  <= 1'b1;
            end else begin
                r_out_wv    <= 1'b1;
                r_out_isd   <= win_isd;
                r_out_byte  <= win_byte;
                r_out_count <= r_count;
                r_out_last  <= win_last;
            end
        end else if (i_cmd.emit_pix) begin
            r_out_wv    <= 1'b1;
            r_out_isd   <= 1'b1;
            r_out_byte  <= r_idx[0] ? r_lo : r_hi;
            r_out_count <= '0;
            r_out_last  <= pix_last;
        end
    end

    assign o_status.in_op    = i_in_op;
    assign o_status.in_zero  = (in_rep == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.win_last = win_last;
    assign o_status.pix_last = pix_last;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(OUT_TDATA_W - BYTE_W - COUNT_W){1'b0}}, r_out_count, r_out_byte};
    assign o_out_user  = {r_out_isd, r_out_wv};
    assign o_out_last  = r_out_last;

endmodule
`default_nettype wire

// ----- src/lcd_window_pixel_writer.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// lcd_window_pixel_writer
// Byte-write generator for an 8-bit parallel display controller bus.
// ---------------------------------------------------------------------------
// A window item (tuser 0) sets the column and page address window from two
// corners, clipped to the display, and ends with the memory-write command:
// eleven bus bytes, or one empty report (write_valid 0, count 0) when the
// window misses the display. Its first byte reaches the output after the
// registered steps order and clip, count, then emit, and the next item is
// taken the cycle after its last byte. A pixel item (tuser 1) gives two
// RGB565 bytes per repeat, one byte per cycle while the output is free, the
// first once the item is registered; the next item is taken on the cycle of
// the last byte, and a zero-repeat pixel gives no bytes. Output tready low
// while a byte waits holds the sequence. A registered output stage lets a
// finished byte wait for tready.
// ---------------------------------------------------------------------------
module lcd_window_pixel_writer
    import lwpw_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = DEF_DISPLAY_WIDTH,
    parameter int DISPLAY_HEIGHT = DEF_DISPLAY_HEIGHT,
    parameter int MAX_REPEAT     = DEF_MAX_REPEAT
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // x_a, y_a, x_b, y_b, red, green, blue, repeat_count, zero pad
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // op
    input  wire logic                   i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // bus_byte, pixel_count, zero pad
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // write_valid, is_data
    output logic [OUT_TUSER_W-1:0]      o_m_axis_tuser,
    // last_of_run
    output logic                        o_m_axis_tlast
);

    t_dp_cmd    cmd;
    t_dp_status status;

    lwpw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lwpw_dp #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
        .MAX_REPEAT     (MAX_REPEAT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_s_axis_tdata),
        .i_in_op     (i_s_axis_tuser),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule
`default_nettype wire
